// ===== sv/cdq_pkg.sv =====
// Shared types and constants for the circular deque.
// No dependencies; every other file of the block uses this package.
package cdq_pkg;

	localparam int DEPTH  = 8;
	localparam int WORD_W = 32;

	typedef enum logic [1:0] {
		REQ_PUSH_FRONT = 2'd0,
		REQ_PUSH_BACK  = 2'd1,
		REQ_POP_FRONT  = 2'd2,
		REQ_POP_BACK   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH_FRONT,
		CELL_PUSH_BACK,
		CELL_POP_FRONT,
		CELL_POP_BACK
	} cell_op_t;

	// Command broadcast to every cell of the row
	typedef struct packed {
		cell_op_t                 op;
		logic signed [WORD_W-1:0] word;
	} cell_cmd_t;

endpackage

// ===== sv/cdq_req_if.sv =====
// Request channel of the circular deque: valid/ready plus request payload.
// Depends on cdq_pkg for the word width.
interface cdq_req_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       req_type;
	logic signed [cdq_pkg::WORD_W-1:0] push_value;

	modport source (output valid, req_type, push_value, input ready);
	modport sink   (input valid, req_type, push_value, output ready);
endinterface

// ===== sv/cdq_rsp_if.sv =====
// Response channel of the circular deque: valid/ready plus result payload.
// Depends on cdq_pkg for the word width.
interface cdq_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [cdq_pkg::WORD_W-1:0] popped_value;
	logic [1:0]                       status;
	logic                             now_empty;
	logic                             now_full;

	modport source (output valid, popped_value, status, now_empty, now_full, input ready);
	modport sink   (input valid, popped_value, status, now_empty, now_full, output ready);
endinterface

// ===== sv/circular_deque.sv =====
// Circular deque top level: a row of DEPTH cells with a registered result.
// Result: the result word of an accepted request is registered and shown in the cycle after it.
// Throughput: one request per cycle while results are taken; the result register frees as it is taken.
// Reset: all cells are marked empty; stored words stay undefined until written.
// Depends on cdq_pkg, cdq_req_if, cdq_rsp_if and cdq_cell.
module circular_deque (
	input  logic      clk,
	input  logic      arst_n,
	cdq_req_if.sink   req,
	cdq_rsp_if.source rsp
);
	import cdq_pkg::*;

	logic [DEPTH-1:0]         valid_vec;
	logic [DEPTH-1:0]         tail_vec;
	logic signed [WORD_W-1:0] data_arr [DEPTH];
	cell_cmd_t                cmd;

	logic                     accept;
	logic                     is_empty;
	logic                     is_full;
	req_t                     rtype;
	logic signed [WORD_W-1:0] back_word;

	logic signed [WORD_W-1:0] popped_d;
	status_t                  status_d;
	logic                     empty_d;
	logic                     full_d;
	cell_op_t                 op_d;

	logic                     rsp_valid_q;
	logic signed [WORD_W-1:0] popped_q;
	status_t                  status_q;
	logic                     empty_q;
	logic                     full_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign rtype     = req_t'(req.req_type);
	assign is_empty  = !valid_vec[0];
	assign is_full   = valid_vec[DEPTH-1];

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                     lv;
			logic signed [WORD_W-1:0] ld;
			logic                     rv;
			logic signed [WORD_W-1:0] rd;
			if (gi == 0) begin : g_first
				assign lv = 1'b1;
				assign ld = cmd.word;
			end else begin : g_mid_l
				assign lv = valid_vec[gi-1];
				assign ld = data_arr[gi-1];
			end
			if (gi == DEPTH-1) begin : g_last
				assign rv = 1'b0;
				assign rd = '0;
			end else begin : g_mid_r
				assign rv = valid_vec[gi+1];
				assign rd = data_arr[gi+1];
			end
			cdq_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd),
				.left_valid  (lv),
				.left_data   (ld),
				.right_valid (rv),
				.right_data  (rd),
				.valid       (valid_vec[gi]),
				.data        (data_arr[gi]),
				.tail        (tail_vec[gi])
			);
		end
	endgenerate

	// at most one cell is the tail, so an OR picks its word
	always_comb begin
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_word = back_word | (tail_vec[i] ? data_arr[i] : '0);
		end
	end

	always_comb begin
		popped_d = '0;
		status_d = ST_OK;
		empty_d  = is_empty;
		full_d   = is_full;
		op_d     = CELL_HOLD;
		case (rtype)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (is_full) begin
					status_d = ST_OVERFLOW;
				end else begin
					op_d    = (rtype == REQ_PUSH_FRONT) ? CELL_PUSH_FRONT : CELL_PUSH_BACK;
					empty_d = 1'b0;
					full_d  = valid_vec[DEPTH-2];
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (is_empty) begin
					status_d = ST_UNDERFLOW;
				end else begin
					op_d     = (rtype == REQ_POP_FRONT) ? CELL_POP_FRONT : CELL_POP_BACK;
					popped_d = (rtype == REQ_POP_FRONT) ? data_arr[0] : back_word;
					empty_d  = !valid_vec[1];
					full_d   = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cmd.op   = accept ? op_d : CELL_HOLD;
		cmd.word = req.push_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req.ready) begin
			rsp_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= popped_d;
			status_q <= status_d;
			empty_q  <= empty_d;
			full_q   <= full_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.status       = status_q;
	assign rsp.now_empty    = empty_q;
	assign rsp.now_full     = full_q;

	// occupied cells form an unbroken run from the front
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("deque cells not contiguous");

	// result flags agree with the cell row once the request has landed
	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (empty_q == !valid_vec[0]) && (full_q == valid_vec[DEPTH-1]))
		else $error("result flags disagree with cell state");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == ST_OVERFLOW |-> full_q && !empty_q)
		else $error("overflow reported on a deque that is not full");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == ST_UNDERFLOW |-> empty_q && popped_q == '0)
		else $error("underflow reported on a deque that is not empty");

endmodule

// ===== sv/cdq_cell.sv =====
// One cell of the deque row: a word and its occupied flag.
// Trades words with its left and right neighbors; uses cdq_pkg.
module cdq_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cdq_pkg::cell_cmd_t                cmd,
	input  logic                              left_valid,
	input  logic signed [cdq_pkg::WORD_W-1:0] left_data,
	input  logic                              right_valid,
	input  logic signed [cdq_pkg::WORD_W-1:0] right_data,
	output logic                              valid,
	output logic signed [cdq_pkg::WORD_W-1:0] data,
	output logic                              tail
);
	import cdq_pkg::*;

	logic                     valid_q;
	logic signed [WORD_W-1:0] data_q;
	logic                     valid_d;
	logic signed [WORD_W-1:0] data_d;
	logic                     data_en;

	always_comb begin
		valid_d = valid_q;
		data_d  = data_q;
		data_en = 1'b0;
		case (cmd.op)
			CELL_PUSH_FRONT: begin
				// shift toward the back, take the left neighbor's word
				valid_d = left_valid;
				data_d  = left_data;
				data_en = 1'b1;
			end
			CELL_PUSH_BACK: begin
				// first free cell takes the new word
				if (!valid_q && left_valid) begin
					valid_d = 1'b1;
					data_d  = cmd.word;
					data_en = 1'b1;
				end
			end
			CELL_POP_FRONT: begin
				valid_d = right_valid;
				data_d  = right_data;
				data_en = 1'b1;
			end
			CELL_POP_BACK: begin
				if (tail) begin
					valid_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (data_en) begin
			data_q <= data_d;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;
	assign tail  = valid_q && !right_valid;

endmodule
